@@ hw/rtl/lsed_pkg.sv @@
// ----------------------------------------------------------------------------
// lsed_pkg
// Shared types, reset thresholds and the direction scale for the escape
// direction block.
// ----------------------------------------------------------------------------
package lsed_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_W     = 10;
  localparam int INDEX_W      = $clog2(SENSOR_COUNT);
  localparam int DIR_W        = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [SENSOR_COUNT-1:0] sample_arr_t;
  typedef logic [INDEX_W-1:0] sensor_idx_t;
  typedef logic [DIR_W-1:0] dir_t;

  // Combinational result of one frame.
  typedef struct packed {
    logic hit;
    dir_t dir;
  } lsed_result_t;

  localparam sample_arr_t THR_RESET = {
    10'd480, 10'd452, 10'd538, 10'd505, 10'd490, 10'd480, 10'd500, 10'd515
  };

  // Gap middle in half-sensor steps (0..15) to the 0..255 circle scale,
  // rounded half up.
  function automatic dir_t dir_from_half(input logic [3:0] h);
    logic [11:0] p;
    p = {8'd0, h} * 12'd255 + 12'd8;
    return p[11:4];
  endfunction

endpackage

@@ hw/rtl/line_sensor_escape_direction.sv @@
// ----------------------------------------------------------------------------
// line_sensor_escape_direction
// Path: an accepted frame is held in the frame register, then its direction beat in the output register.
// Throughput: one frame per cycle while the output is not stalled; frame register, then compare and gap logic.
// Reset: synchronous; clears both valid flags and reloads default thresholds.
// ----------------------------------------------------------------------------
module line_sensor_escape_direction import lsed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  sensor_idx_t cfg_index,
  input  sample_t     cfg_wdata,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample_0,
  input  sample_t     sample_1,
  input  sample_t     sample_2,
  input  sample_t     sample_3,
  input  sample_t     sample_4,
  input  sample_t     sample_5,
  input  sample_t     sample_6,
  input  sample_t     sample_7,
  output logic        direction_valid,
  input  logic        direction_ready,
  output dir_t        direction_byte
);

  sample_arr_t  thr;
  sample_arr_t  frame;
  logic         frame_valid;
  lsed_result_t result;
  logic         out_free;
  logic         frame_go;

  lsed_thr_regs u_thr (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  lsed_core u_core (
    .samples (frame),
    .thr     (thr),
    .result  (result)
  );

  // A frame with no sensor on the line leaves without a beat.
  assign out_free     = !direction_valid || direction_ready;
  assign frame_go     = frame_valid && (!result.hit || out_free);
  assign sample_ready = !frame_valid || frame_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid     <= 1'b0;
      direction_valid <= 1'b0;
    end else begin
      if (sample_ready) begin
        frame_valid <= sample_valid;
      end
      if (frame_go && result.hit) begin
        direction_valid <= 1'b1;
      end else if (direction_ready) begin
        direction_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      frame <= {sample_7, sample_6, sample_5, sample_4,
                sample_3, sample_2, sample_1, sample_0};
    end
    if (frame_go && result.hit) begin
      direction_byte <= result.dir;
    end
  end

endmodule

@@ hw/rtl/lsed_thr_regs.sv @@
// ----------------------------------------------------------------------------
// lsed_thr_regs
// Per-sensor on-line threshold registers behind the plain write port.
// ----------------------------------------------------------------------------
module lsed_thr_regs import lsed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  sensor_idx_t cfg_index,
  input  sample_t     cfg_wdata,
  output sample_arr_t thr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr[cfg_index] <= cfg_wdata;
    end
  end

endmodule

@@ hw/rtl/lsed_core.sv @@
// ----------------------------------------------------------------------------
// lsed_core
// Threshold compare, ring gap search and direction scaling for one frame.
// ----------------------------------------------------------------------------
module lsed_core import lsed_pkg::*; (
  input  sample_arr_t  samples,
  input  sample_arr_t  thr,
  output lsed_result_t result
);

  logic [SENSOR_COUNT-1:0] on_line;
  logic [INDEX_W:0]        gap [SENSOR_COUNT];
  logic [INDEX_W:0]        best_gap;
  sensor_idx_t             best_start;
  logic [INDEX_W+1:0]      h_full;

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      on_line[i] = (samples[i] <= thr[i]);
    end
  end

  // Distance from each sensor to the next on-line sensor around the ring.
  // A lone sensor sees the whole ring.
  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      gap[i] = (INDEX_W+1)'(SENSOR_COUNT);
      for (int j = SENSOR_COUNT - 1; j >= 1; j--) begin
        if (on_line[(i + j) % SENSOR_COUNT]) begin
          gap[i] = (INDEX_W+1)'(j);
        end
      end
    end
  end

  // Walk in ascending order; a strict compare keeps the earliest gap on a tie.
  always_comb begin
    best_gap   = '0;
    best_start = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (on_line[i] && (gap[i] > best_gap)) begin
        best_gap   = gap[i];
        best_start = sensor_idx_t'(i);
      end
    end
  end

  // The sum stays below 32, so wrapping by 16 is just the low four bits.
  assign h_full     = {1'b0, best_start, 1'b0} + {1'b0, best_gap};
  assign result.hit = |on_line;
  assign result.dir = dir_from_half(h_full[3:0]);

endmodule

@@ hw/rtl/lsed_checker.sv @@
// ----------------------------------------------------------------------------
// lsed_checker
// Port-level checks on the escape direction block, bound to the top level.
// ----------------------------------------------------------------------------
module lsed_checker import lsed_pkg::*; (
  input logic clk,
  input logic rst,
  input logic sample_ready,
  input logic direction_valid,
  input logic direction_ready,
  input dir_t direction_byte
);

  // A beat that is not taken stays up.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    direction_valid && !direction_ready |=> direction_valid)
    else $error("direction beat dropped while stalled");

  // The half-sensor scale never reaches past 239.
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    direction_valid |-> (direction_byte <= 8'd239))
    else $error("direction out of range");

  // With the output empty nothing can hold the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !direction_valid |-> sample_ready)
    else $error("input stalled while output is empty");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !direction_valid)
    else $error("result valid right after reset");

endmodule

bind line_sensor_escape_direction lsed_checker u_lsed_checker (.*);
